/* design/ikev2_pkg.sv */
package ikev2_pkg;

  localparam int unsigned MaxChainPayloadsDefault = 32;

  localparam logic [16:0] HdrBytes   = 17'd28;
  localparam logic [16:0] MarkBytes  = 17'd4;
  localparam logic [16:0] CountMax   = 17'h1FFFF;
  localparam logic [7:0]  KindNotify = 8'd41;
  localparam logic [15:0] CookieType = 16'd16390;

  typedef enum logic [1:0] {
    CFG_MAX_SIZE = 2'd0,
    CFG_NATT     = 2'd1,
    CFG_SA_INIT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_OVERSIZE  = 4'd2,
    ST_MARKER    = 4'd3,
    ST_VERSION   = 4'd4,
    ST_FLAGS     = 4'd5,
    ST_LENGTH    = 4'd6,
    ST_EXCHANGE  = 4'd7,
    ST_SPI       = 4'd8,
    ST_PL_LIMIT  = 4'd9,
    ST_PL_LENGTH = 4'd10,
    ST_CRITICAL  = 4'd11,
    ST_MISSING   = 4'd12
  } status_t;

  function automatic logic kind_known(input logic [7:0] k);
    return (k == 8'd0) || (k >= 8'd33 && k <= 8'd48) || (k == 8'd53);
  endfunction

  // Bit position plus one in the seen mask; zero means not tracked.
  function automatic logic [3:0] seen_code(input logic [7:0] k);
    case (k)
      8'd33:   return 4'd1;
      8'd34:   return 4'd2;
      8'd35:   return 4'd5;
      8'd36:   return 4'd6;
      8'd39:   return 4'd7;
      8'd40:   return 4'd3;
      8'd41:   return 4'd4;
      8'd44:   return 4'd9;
      8'd45:   return 4'd10;
      8'd48:   return 4'd8;
      default: return 4'd0;
    endcase
  endfunction

endpackage

/* design/ikev2_message_checker.sv */
// IKEv2 datagram checker. Feed a datagram one byte per item, last_byte set on
// its final byte; one status result with the header fields, payload count,
// seen-payload mask and cookie position follows that byte. A single registered
// pass updates the header and chain-walk state, and the result sits in an
// output register, so bytes stream at one per cycle while out_ready is high.
// Configuration writes apply from the next byte and should be made between
// datagrams.
module ikev2_message_checker #(
  parameter int unsigned MAX_CHAIN_PAYLOADS = ikev2_pkg::MaxChainPayloadsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [63:0] out_spi_init,
  output logic [63:0] out_spi_resp,
  output logic [7:0]  out_exchange_kind,
  output logic [7:0]  out_header_flags,
  output logic [31:0] out_message_number,
  output logic [7:0]  out_payload_total,
  output logic [9:0]  out_seen_mask,
  output logic        out_cookie_present,
  output logic [15:0] out_cookie_start,
  output logic [6:0]  out_cookie_bytes
);
  import ikev2_pkg::*;

  localparam logic [7:0] ChainLimit = 8'(MAX_CHAIN_PAYLOADS);

  logic [15:0] max_size_r;
  logic        natt_r, sa_mode_r;

  logic [16:0] byte_count_r, byte_count_nxt;
  logic [63:0] spi_i_r, spi_i_nxt, spi_r_r, spi_r_nxt;
  logic [31:0] small_r, small_nxt, msg_id_r, msg_id_nxt;
  logic [31:0] decl_len_r, decl_len_nxt;
  logic        marker_nz_r, marker_nz_nxt;
  logic [3:0]  chain_err_r, chain_err_nxt;
  logic [7:0]  cur_kind_r, cur_kind_nxt;
  logic [31:0] head_r, head_nxt;
  logic [3:0]  head_fill_r, head_fill_nxt;
  logic [7:0]  next_kind_r, next_kind_nxt;
  logic [16:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [9:0]  seen_r, seen_nxt;
  logic [15:0] ck_start_r, ck_start_nxt;
  logic [6:0]  ck_len_r, ck_len_nxt;
  logic        ck_present_r, ck_present_nxt;
  logic        ended_r, ended_nxt;
  logic        live_r, live_nxt;

  logic        accept;
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= 16'hFFFF;
      natt_r     <= 1'b0;
      sa_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_SIZE: max_size_r <= cfg_data;
        CFG_NATT:     natt_r     <= cfg_data[0];
        CFG_SA_INIT:  sa_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Per-byte state update.
  always_comb begin
    logic [16:0] off, b, p, pos, room;
    logic [7:0]  d;
    logic [31:0] hd;
    logic [15:0] len;
    logic [3:0]  sc;
    logic        do_enter, rec;
    logic [7:0]  rec_kind;

    byte_count_nxt = byte_count_r; spi_i_nxt = spi_i_r; spi_r_nxt = spi_r_r;
    small_nxt = small_r; msg_id_nxt = msg_id_r; decl_len_nxt = decl_len_r;
    marker_nz_nxt = marker_nz_r; chain_err_nxt = chain_err_r;
    cur_kind_nxt = cur_kind_r; head_nxt = head_r; head_fill_nxt = head_fill_r;
    next_kind_nxt = next_kind_r; bytes_left_nxt = bytes_left_r;
    count_nxt = count_r; seen_nxt = seen_r; ck_start_nxt = ck_start_r;
    ck_len_nxt = ck_len_r; ck_present_nxt = ck_present_r;
    ended_nxt = ended_r; live_nxt = live_r;

    off = natt_r ? MarkBytes : 17'd0;
    b = byte_count_r;
    p = b - off;
    d = in_data_byte;
    hd = {head_r[23:0], d};
    len = hd[15:0];
    do_enter = 1'b0;
    rec = 1'b0;
    rec_kind = cur_kind_r;
    pos = 17'd0;
    room = 17'd0;
    sc = 4'd0;

    if (b != CountMax) begin
      byte_count_nxt = b + 17'd1;
      if (b < off) begin
        if (d != 8'd0) marker_nz_nxt = 1'b1;
      end else if (p < HdrBytes) begin
        if (p < 17'd8) spi_i_nxt = {spi_i_r[55:0], d};
        else if (p < 17'd16) spi_r_nxt = {spi_r_r[55:0], d};
        else if (p == 17'd16) small_nxt[31:24] = d;
        else if (p == 17'd17) small_nxt[23:16] = d;
        else if (p == 17'd18) small_nxt[15:8] = d;
        else if (p == 17'd19) small_nxt[7:0] = d;
        else if (p < 17'd24) msg_id_nxt = {msg_id_r[23:0], d};
        else decl_len_nxt = {decl_len_r[23:0], d};
        if (p == HdrBytes - 17'd1) begin
          live_nxt = 1'b1;
          cur_kind_nxt = small_r[31:24];
          do_enter = 1'b1;
        end
      end else if (live_r && !ended_r && chain_err_r == 4'd0) begin
        if (head_fill_r < 4'd4) begin
          head_nxt = hd;
          head_fill_nxt = head_fill_r + 4'd1;
          if (head_fill_r == 4'd0) next_kind_nxt = d;
          if (head_fill_r == 4'd3) begin
            if (len < 16'd4 || 17'(len) > bytes_left_r) chain_err_nxt = ST_PL_LENGTH;
            else if (hd[23] && !kind_known(cur_kind_r)) chain_err_nxt = ST_CRITICAL;
            else begin
              bytes_left_nxt = 17'(len) - 17'd4;
              if (cur_kind_r == KindNotify) begin
                if (len < 16'd8) chain_err_nxt = ST_PL_LENGTH;
              end else begin
                rec = 1'b1;
                head_fill_nxt = 4'd8;
                do_enter = (len == 16'd4);
                cur_kind_nxt = next_kind_r;
              end
            end
          end
        end else begin
          if (bytes_left_r != 17'd0) bytes_left_nxt = bytes_left_r - 17'd1;
          if (head_fill_r < 4'd8) begin
            head_nxt = hd;
            head_fill_nxt = head_fill_r + 4'd1;
            if (head_fill_r == 4'd7) begin
              if (hd[31:24] == 8'd0 && hd[23:16] == 8'd0 && len == CookieType &&
                  (bytes_left_nxt < 17'd1 || bytes_left_nxt > 17'd64)) begin
                chain_err_nxt = ST_PL_LENGTH;
              end else begin
                if (hd[31:24] == 8'd0 && hd[23:16] == 8'd0 && len == CookieType) begin
                  ck_start_nxt = byte_count_nxt[15:0];
                  ck_len_nxt = bytes_left_nxt[6:0];
                  ck_present_nxt = 1'b1;
                end
                rec = 1'b1;
                do_enter = (bytes_left_nxt == 17'd0);
                if (do_enter) cur_kind_nxt = next_kind_r;
              end
            end
          end else begin
            do_enter = (bytes_left_nxt == 17'd0);
            if (do_enter) cur_kind_nxt = next_kind_r;
          end
        end
      end
    end

    // Record the payload kind that just finished its header.
    if (rec) begin
      count_nxt = count_r + 8'd1;
      sc = seen_code(rec_kind);
      if (sc != 4'd0) seen_nxt[sc - 4'd1] = 1'b1;
    end

    // Start the next payload of the chain, or close the chain when the next kind is zero.
    if (do_enter) begin
      pos = byte_count_nxt >= off ? byte_count_nxt - off : 17'd0;
      room = (decl_len_nxt > 32'(pos)) ? 17'((decl_len_nxt - 32'(pos)) > 32'(CountMax) ?
             32'(CountMax) : (decl_len_nxt - 32'(pos))) : 17'd0;
      if (cur_kind_nxt == 8'd0) begin
        ended_nxt = 1'b1;
        if (32'(pos) != decl_len_nxt) chain_err_nxt = ST_PL_LENGTH;
      end else if (count_nxt >= ChainLimit) begin
        chain_err_nxt = ST_PL_LIMIT;
      end else if (room < 17'd4) begin
        chain_err_nxt = ST_PL_LENGTH;
      end else begin
        bytes_left_nxt = room;
        head_nxt = 32'd0;
        head_fill_nxt = 4'd0;
      end
    end
  end

  // Final verdict on the updated state.
  logic [3:0] st;
  logic       hdr_ok, sum_ok;
  always_comb begin
    logic [16:0] off;
    logic [7:0]  ver, exch, flg;
    off = natt_r ? MarkBytes : 17'd0;
    ver = small_nxt[23:16]; exch = small_nxt[15:8]; flg = small_nxt[7:0];
    hdr_ok = 1'b0; sum_ok = 1'b0;
    if (byte_count_nxt < off + HdrBytes) st = ST_SHORT;
    else if (max_size_r == 16'd0 || byte_count_nxt > 17'(max_size_r)) st = ST_OVERSIZE;
    else if (natt_r && marker_nz_nxt) st = ST_MARKER;
    else begin
      hdr_ok = 1'b1;
      if (ver[7:4] != 4'd2) st = ST_VERSION;
      else if (flg[4]) st = ST_FLAGS;
      else if (decl_len_nxt < 32'(HdrBytes) || decl_len_nxt != 32'(byte_count_nxt - off))
        st = ST_LENGTH;
      else if (exch < 8'd34 || exch > 8'd37) st = ST_EXCHANGE;
      else if (spi_i_nxt == 64'd0 || (exch == 8'd34 && !flg[5] && spi_r_nxt != 64'd0))
        st = ST_SPI;
      else if (sa_mode_r && (exch != 8'd34 || flg[5] || !flg[3] ||
               spi_r_nxt != 64'd0 || msg_id_nxt != 32'd0)) st = ST_SPI;
      else begin
        sum_ok = 1'b1;
        if (chain_err_nxt != 4'd0) st = chain_err_nxt;
        else if (!live_nxt || !ended_nxt) st = ST_PL_LENGTH;
        else if (sa_mode_r && seen_nxt[2:0] != 3'b111) st = ST_MISSING;
        else st = ST_OK;
      end
    end
  end

  // State registers; clear after the final byte.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last_byte)) begin
      byte_count_r <= '0; spi_i_r <= '0; spi_r_r <= '0; small_r <= '0;
      msg_id_r <= '0; decl_len_r <= '0; marker_nz_r <= 1'b0; chain_err_r <= '0;
      cur_kind_r <= '0; head_r <= '0; head_fill_r <= '0; next_kind_r <= '0;
      bytes_left_r <= '0; count_r <= '0; seen_r <= '0; ck_start_r <= '0;
      ck_len_r <= '0; ck_present_r <= 1'b0; ended_r <= 1'b0; live_r <= 1'b0;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt; spi_i_r <= spi_i_nxt; spi_r_r <= spi_r_nxt;
      small_r <= small_nxt; msg_id_r <= msg_id_nxt; decl_len_r <= decl_len_nxt;
      marker_nz_r <= marker_nz_nxt; chain_err_r <= chain_err_nxt;
      cur_kind_r <= cur_kind_nxt; head_r <= head_nxt; head_fill_r <= head_fill_nxt;
      next_kind_r <= next_kind_nxt; bytes_left_r <= bytes_left_nxt;
      count_r <= count_nxt; seen_r <= seen_nxt; ck_start_r <= ck_start_nxt;
      ck_len_r <= ck_len_nxt; ck_present_r <= ck_present_nxt;
      ended_r <= ended_nxt; live_r <= live_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (accept && in_last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last_byte) begin
      out_status         <= st;
      out_spi_init       <= hdr_ok ? spi_i_nxt : 64'd0;
      out_spi_resp       <= hdr_ok ? spi_r_nxt : 64'd0;
      out_exchange_kind  <= hdr_ok ? small_nxt[15:8] : 8'd0;
      out_header_flags   <= hdr_ok ? small_nxt[7:0] : 8'd0;
      out_message_number <= hdr_ok ? msg_id_nxt : 32'd0;
      out_payload_total  <= sum_ok ? count_nxt : 8'd0;
      out_seen_mask      <= sum_ok ? seen_nxt : 10'd0;
      out_cookie_present <= sum_ok ? ck_present_nxt : 1'b0;
      out_cookie_start   <= sum_ok ? ck_start_nxt : 16'd0;
      out_cookie_bytes   <= sum_ok ? ck_len_nxt : 7'd0;
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input blocked with empty output");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |=> byte_count_r == 17'd0 && !live_r)
    else $error("state not cleared after datagram");
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ChainLimit) else $error("payload count beyond limit");
`endif

endmodule
